FILE: design/fpct_pkg.sv
// Package for the frustum plane cull test: shared types and constants.
// Used by fpct_cell and frustum_plane_cull_test; depends on nothing.
package fpct_pkg;

  // Query kinds carried on in_tuser.
  localparam logic [1:0] OP_POINT_IN  = 2'd0;
  localparam logic [1:0] OP_SPHERE_X  = 2'd1;
  localparam logic [1:0] OP_BOX_X     = 2'd2;
  localparam logic [1:0] OP_BOX_IN    = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PLANE_NEAR = 3'd0;
  localparam logic [2:0] CFG_PLANE_FAR  = 3'd5;
  localparam logic [2:0] CFG_FAR_EN     = 3'd6;

  localparam int PLANE_W     = 64;
  localparam int NORMAL_W    = 16;
  localparam int NORMAL_FRAC = 14;
  localparam int FAR_IDX     = 5;

  // Control that travels along the cell chain with every query.
  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [1:0] op;
  } cell_ctl_t;

endpackage

FILE: design/fpct_cell.sv
// One plane cell of the cull chain: holds one plane register and tests it.
// Two register stages per cell (products, then sum and compare); uses fpct_pkg.
module fpct_cell
  import fpct_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          cfg_we,
  input  logic [PLANE_W-1:0]            cfg_data,
  input  logic                          active,
  input  cell_ctl_t                     ctl_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] cz_i,
  input  logic [COORD_WIDTH-2:0]        ex_i,
  input  logic [COORD_WIDTH-2:0]        ey_i,
  input  logic [COORD_WIDTH-2:0]        ez_i,
  output cell_ctl_t                     ctl_o,
  output logic signed [COORD_WIDTH-1:0] cx_o,
  output logic signed [COORD_WIDTH-1:0] cy_o,
  output logic signed [COORD_WIDTH-1:0] cz_o,
  output logic [COORD_WIDTH-2:0]        ex_o,
  output logic [COORD_WIDTH-2:0]        ey_o,
  output logic [COORD_WIDTH-2:0]        ez_o
);

  localparam int PW    = NORMAL_W + COORD_WIDTH;
  localparam int AW    = NORMAL_W + 1 + COORD_WIDTH;
  localparam int ACC_W = ((PW > 31) ? PW : 31) + 4;

  logic [PLANE_W-1:0] plane_r;

  logic signed [NORMAL_W-1:0] nx, ny, nz, plane_dist;
  logic signed [NORMAL_W:0]   anx, any_n, anz;
  logic signed [PW-1:0]       pcx, pcy, pcz;
  logic signed [AW-1:0]       pex, pey, pez;

  // Stage A registers.
  cell_ctl_t                     ctl_a_r;
  logic signed [PW-1:0]          pcx_r, pcy_r, pcz_r;
  logic signed [AW-1:0]          pex_r, pey_r, pez_r;
  logic signed [NORMAL_W-1:0]    dist_r;
  logic signed [COORD_WIDTH-1:0] cx_a_r, cy_a_r, cz_a_r;
  logic [COORD_WIDTH-2:0]        ex_a_r, ey_a_r, ez_a_r;

  // Stage B.
  cell_ctl_t                     ctl_b_r;
  logic signed [COORD_WIDTH-1:0] cx_b_r, cy_b_r, cz_b_r;
  logic [COORD_WIDTH-2:0]        ex_b_r, ey_b_r, ez_b_r;
  logic signed [ACC_W-1:0]       dot, box_slack, slack, total;
  logic                          plane_ok;

  assign nx         = plane_r[15:0];
  assign ny         = plane_r[31:16];
  assign nz         = plane_r[47:32];
  assign plane_dist = plane_r[63:48];

  // The absolute normal needs one extra bit for the most negative code.
  assign anx   = nx[NORMAL_W-1] ? ((NORMAL_W+1)'(0) - (NORMAL_W+1)'(nx)) : (NORMAL_W+1)'(nx);
  assign any_n = ny[NORMAL_W-1] ? ((NORMAL_W+1)'(0) - (NORMAL_W+1)'(ny)) : (NORMAL_W+1)'(ny);
  assign anz   = nz[NORMAL_W-1] ? ((NORMAL_W+1)'(0) - (NORMAL_W+1)'(nz)) : (NORMAL_W+1)'(nz);

  assign pcx = nx * cx_i;
  assign pcy = ny * cy_i;
  assign pcz = nz * cz_i;
  assign pex = anx * $signed({1'b0, ex_i});
  assign pey = any_n * $signed({1'b0, ey_i});
  assign pez = anz * $signed({1'b0, ez_i});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (cfg_we) begin
      plane_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else if (en) begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= '{valid: ctl_a_r.valid, ok: ctl_a_r.ok & plane_ok, op: ctl_a_r.op};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcx_r  <= pcx;
      pcy_r  <= pcy;
      pcz_r  <= pcz;
      pex_r  <= pex;
      pey_r  <= pey;
      pez_r  <= pez;
      dist_r <= plane_dist;
      cx_a_r <= cx_i;
      cy_a_r <= cy_i;
      cz_a_r <= cz_i;
      ex_a_r <= ex_i;
      ey_a_r <= ey_i;
      ez_a_r <= ez_i;
      cx_b_r <= cx_a_r;
      cy_b_r <= cy_a_r;
      cz_b_r <= cz_a_r;
      ex_b_r <= ex_a_r;
      ey_b_r <= ey_a_r;
      ez_b_r <= ez_a_r;
    end
  end

  always_comb begin
    dot = ACC_W'(pcx_r) + ACC_W'(pcy_r) + ACC_W'(pcz_r)
        - (ACC_W'(dist_r) <<< NORMAL_FRAC);
    box_slack = ACC_W'(pex_r) + ACC_W'(pey_r) + ACC_W'(pez_r);
    case (ctl_a_r.op)
      OP_POINT_IN: slack = '0;
      OP_SPHERE_X: slack = ACC_W'($signed({1'b0, ex_a_r})) <<< NORMAL_FRAC;
      OP_BOX_X:    slack = box_slack;
      OP_BOX_IN:   slack = -box_slack;
      default:     slack = '0;
    endcase
    total    = dot + slack;
    // An inactive plane lets every query through.
    plane_ok = !active || !total[ACC_W-1];
  end

  assign ctl_o = ctl_b_r;
  assign cx_o  = cx_b_r;
  assign cy_o  = cy_b_r;
  assign cz_o  = cz_b_r;
  assign ex_o  = ex_b_r;
  assign ey_o  = ey_b_r;
  assign ez_o  = ez_b_r;

endmodule

FILE: design/frustum_plane_cull_test.sv
// Top level of the frustum plane cull test: cell chain and output register.
// Instantiates fpct_cell once per plane; uses fpct_pkg.
//
// A query beat (kind on in_tuser, centre and half extents on in_tdata) runs
// through a chain of NUM_PLANES plane cells, two register stages per cell,
// and its result then passes through the output register. One query is
// accepted every cycle; the whole chain advances together and holds only
// while a result waits on out_tready. Each cell keeps its own plane register.
// Plane registers are written through the cfg port at indexes 0 to 5
// (near, right, left, bottom, top, far), index 6 sets the far-plane enable;
// write them only while no query is in flight.
module frustum_plane_cull_test
  import fpct_pkg::*;
#(
  parameter int NUM_PLANES  = 6,
  parameter int COORD_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // Lowest bit up: center_x, center_y, center_z, extent_x, extent_y, extent_z, zero fill.
  input  logic [((6*COORD_WIDTH-3)+7)/8*8-1:0] in_tdata,
  // Bits 1:0: op.
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // Bit 0: passes; the rest is zero fill.
  output logic [7:0]           out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [PLANE_W-1:0]   cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int EW = COORD_WIDTH - 1;

  cell_ctl_t                ctl_c [NUM_PLANES+1];
  logic signed [CW-1:0]     cx_c  [NUM_PLANES+1];
  logic signed [CW-1:0]     cy_c  [NUM_PLANES+1];
  logic signed [CW-1:0]     cz_c  [NUM_PLANES+1];
  logic [EW-1:0]            ex_c  [NUM_PLANES+1];
  logic [EW-1:0]            ey_c  [NUM_PLANES+1];
  logic [EW-1:0]            ez_c  [NUM_PLANES+1];

  logic far_en_r;
  logic out_valid_r;
  logic out_passes_r;
  logic adv;

  // The chain moves whenever the output slot is free or being emptied.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  assign ctl_c[0].valid = in_tvalid;
  assign ctl_c[0].ok    = 1'b1;
  assign ctl_c[0].op    = in_tuser;
  assign cx_c[0] = in_tdata[CW-1:0];
  assign cy_c[0] = in_tdata[2*CW-1:CW];
  assign cz_c[0] = in_tdata[3*CW-1:2*CW];
  assign ex_c[0] = in_tdata[3*CW+EW-1:3*CW];
  assign ey_c[0] = in_tdata[3*CW+2*EW-1:3*CW+EW];
  assign ez_c[0] = in_tdata[3*CW+3*EW-1:3*CW+2*EW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_en_r <= 1'b1;
    end else if (cfg_valid && cfg_index == CFG_FAR_EN) begin
      far_en_r <= cfg_data[0];
    end
  end

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    logic cell_we;
    logic cell_active;

    assign cell_we     = cfg_valid && (cfg_index == CFG_PLANE_NEAR + 3'(i));
    assign cell_active = (i == FAR_IDX) ? far_en_r : 1'b1;

    fpct_cell #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .cfg_we  (cell_we),
      .cfg_data(cfg_data),
      .active  (cell_active),
      .ctl_i   (ctl_c[i]),
      .cx_i    (cx_c[i]),
      .cy_i    (cy_c[i]),
      .cz_i    (cz_c[i]),
      .ex_i    (ex_c[i]),
      .ey_i    (ey_c[i]),
      .ez_i    (ez_c[i]),
      .ctl_o   (ctl_c[i+1]),
      .cx_o    (cx_c[i+1]),
      .cy_o    (cy_c[i+1]),
      .cz_o    (cz_c[i+1]),
      .ex_o    (ex_c[i+1]),
      .ey_o    (ey_c[i+1]),
      .ez_o    (ez_c[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_c[NUM_PLANES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_passes_r <= ctl_c[NUM_PLANES].ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_passes_r};

endmodule

FILE: test/tb_frustum_plane_cull_test.sv
// Self-checking testbench for frustum_plane_cull_test: directed and random cull queries,
// each checked against a frustum predictor kept inside this file or against a fixed expected value.
// Depends on fpct_pkg and the frustum_plane_cull_test RTL only.
`timescale 1ns / 100ps

module tb_frustum_plane_cull_test;
  import fpct_pkg::*;

  localparam int NUM_PLANES  = 6;
  localparam int COORD_WIDTH = 16;
  localparam int TDATA_W     = ((6*COORD_WIDTH-3)+7)/8*8;
  localparam int LATENCY     = 2*NUM_PLANES+1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam longint NORMAL_ONE = longint'(1) << NORMAL_FRAC;

  localparam logic [2:0] CFG_PLANE_RIGHT  = 3'd1;
  localparam logic [2:0] CFG_PLANE_LEFT   = 3'd2;
  localparam logic [2:0] CFG_PLANE_BOTTOM = 3'd3;
  localparam logic [2:0] CFG_PLANE_TOP    = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
    logic [14:0] ex;
    logic [14:0] ey;
    logic [14:0] ez;
  } query_t;

  typedef enum logic {ROW_CFG, ROW_QUERY} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [63:0] word;
    query_t      q;
    logic        typed;
    logic        want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic [1:0]         in_tuser = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;

  // Shadow copy of the block's configuration.
  logic [63:0] plane_regs [6];
  logic        far_en;

  logic   expected_passes [$];
  query_t cur_query = '0;
  logic   row_typed = 1'b0;
  logic   row_want = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;

  int errors = 0;
  int results_seen = 0;
  int passing = 0;
  int settings_count = 0;
  int cycle_count = 0;

  frustum_plane_cull_test #(
    .NUM_PLANES(NUM_PLANES),
    .COORD_WIDTH(COORD_WIDTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_frustum_plane_cull_test: errors");
      $finish;
    end
  end

  // Signed distance of the query to every active plane, widened with its slack.
  function automatic logic frustum_passes(query_t q);
    longint nrm [3];
    longint ctr [3];
    longint ext [3];
    longint pdist, sum, slack, a;
    int nplanes;
    logic ok;
    ctr[0] = longint'($signed(q.cx));
    ctr[1] = longint'($signed(q.cy));
    ctr[2] = longint'($signed(q.cz));
    ext[0] = longint'(q.ex);
    ext[1] = longint'(q.ey);
    ext[2] = longint'(q.ez);
    ok = 1'b1;
    nplanes = (far_en && NUM_PLANES >= 6) ? 6 : 5;
    for (int p = 0; p < nplanes; p++) begin
      for (int k = 0; k < 3; k++)
        nrm[k] = longint'($signed(plane_regs[p][16*k +: 16]));
      pdist = longint'($signed(plane_regs[p][63:48]));
      sum = nrm[0]*ctr[0] + nrm[1]*ctr[1] + nrm[2]*ctr[2] - pdist*NORMAL_ONE;
      case (q.op)
        OP_POINT_IN: slack = 0;
        OP_SPHERE_X: slack = ext[0]*NORMAL_ONE;
        default: begin
          slack = 0;
          for (int k = 0; k < 3; k++) begin
            a = (nrm[k] < 0) ? -nrm[k] : nrm[k];
            slack += a*ext[k];
          end
          if (q.op == OP_BOX_IN)
            slack = -slack;
        end
      endcase
      if (sum + slack < 0)
        ok = 1'b0;
    end
    return ok;
  endfunction

  // Result checking and prediction, both sampled at the rising edge.
  always @(posedge clk) begin
    logic want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_passes.size() == 0) begin
          $error("result beat with no query outstanding (passes=%0b)", out_tdata[0]);
          errors++;
        end else begin
          want = expected_passes.pop_front();
          if (out_tdata[0] !== want) begin
            $error("passes: expected %0b, got %0b", want, out_tdata[0]);
            errors++;
          end
          results_seen++;
          if (want)
            passing++;
        end
      end
      if (in_tvalid && in_tready)
        expected_passes.push_back(row_typed ? row_want : frustum_passes(cur_query));
    end
  end

  // Result side: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic int rnd_signed(int lim);
    return int'($urandom_range(0, 2*lim)) - lim;
  endfunction

  function automatic logic [63:0] plane_word(int nx, int ny, int nz, int d);
    return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  function automatic query_t make_query(logic [1:0] op, int cx, int cy, int cz,
                                        int ex, int ey, int ez);
    query_t q;
    q.op = op;
    q.cx = 16'(cx);
    q.cy = 16'(cy);
    q.cz = 16'(cz);
    q.ex = 15'(ex);
    q.ey = 15'(ey);
    q.ez = 15'(ez);
    return q;
  endfunction

  // Mostly geometry near the frustum so that passes and culls both occur.
  function automatic query_t rand_query(int scale);
    query_t q;
    int lim;
    lim = (2*scale > 32767) ? 32767 : 2*scale;
    q.op = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 8) begin
      q.cx = 16'(rnd_signed(lim));
      q.cy = 16'(rnd_signed(lim));
      q.cz = 16'(rnd_signed(lim));
    end else begin
      q.cx = 16'($urandom);
      q.cy = 16'($urandom);
      q.cz = 16'($urandom);
    end
    if ($urandom_range(0, 9) < 7) begin
      q.ex = 15'($urandom_range(0, scale/2));
      q.ey = 15'($urandom_range(0, scale/2));
      q.ez = 15'($urandom_range(0, scale/2));
    end else begin
      q.ex = 15'($urandom);
      q.ey = 15'($urandom);
      q.ez = 15'($urandom);
    end
    return q;
  endfunction

  // All tasks below are entered and left right after a falling edge.
  task automatic offer_query(input query_t q, input logic typed, input logic want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = q.op;
    in_tdata = {3'b000, q.ez, q.ey, q.ex, q.cz, q.cy, q.cx};
    cur_query = q;
    row_typed = typed;
    row_want = want;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (expected_passes.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx <= CFG_PLANE_FAR)
      plane_regs[idx] = val;
    else if (idx == CFG_FAR_EN)
      far_en = val[0];
  endtask

  // Loads one plane setting for the given phase and returns the scale of its geometry.
  task automatic program_planes(input int ph, output int scale);
    int axis_of [6];
    bit lower [6];
    int nrm [3];
    int h;
    logic [63:0] w;
    axis_of = '{2, 0, 0, 1, 1, 2};
    lower = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    settings_count++;
    case (ph)
      3: begin
        // Extreme register values, including a zero plane; far plane off.
        scale = 32767;
        write_reg(CFG_PLANE_NEAR, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PLANE_RIGHT, 64'h8000_8000_8000_8000);
        write_reg(CFG_PLANE_LEFT, 64'h0);
        write_reg(CFG_PLANE_BOTTOM, {16'h8000, 48'h0});
        write_reg(CFG_PLANE_TOP, plane_word(16384, 0, 0, 0));
        write_reg(CFG_PLANE_FAR, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(CFG_FAR_EN, 64'h0);
      end
      6: begin
        // Arbitrary normals with a permissive distance.
        scale = 32767;
        for (int p = 0; p < 6; p++) begin
          w = {$urandom, $urandom};
          w[63:48] = 16'(-int'($urandom_range(16384, 32768)));
          write_reg(3'(p), w);
        end
        write_reg(CFG_FAR_EN, 64'h1);
      end
      default: begin
        // Slightly tilted box frustum of random size.
        h = $urandom_range(100, 20000);
        scale = h;
        for (int p = 0; p < 6; p++) begin
          for (int k = 0; k < 3; k++)
            nrm[k] = rnd_signed(1500);
          nrm[axis_of[p]] = (lower[p] ? 1 : -1) * (int'(NORMAL_ONE) + rnd_signed(2000));
          write_reg(3'(p), plane_word(nrm[0], nrm[1], nrm[2], -h + rnd_signed(h/10)));
        end
        write_reg(CFG_FAR_EN, (ph == 1 || ph == 5) ? 64'h0 : 64'h1);
      end
    endcase
  endtask

  function automatic dir_row_t qrow(logic [1:0] op, int cx, int cy, int cz,
                                    int ex, int ey, int ez, logic typed, logic want);
    dir_row_t r;
    r.kind = ROW_QUERY;
    r.idx = '0;
    r.word = '0;
    r.q = make_query(op, cx, cy, cz, ex, ey, ez);
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic dir_row_t crow(logic [2:0] idx, logic [63:0] word);
    dir_row_t r;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.word = word;
    r.q = '0;
    r.typed = 1'b0;
    r.want = 1'b0;
    return r;
  endfunction

  initial begin
    dir_row_t directed_rows [$];
    int scale;

    for (int p = 0; p < 6; p++)
      plane_regs[p] = '0;
    far_en = 1'b1;

    // After reset every plane is zero, so every query passes.
    directed_rows.push_back(qrow(OP_POINT_IN, -32768, 32767, -32768, 32767, 0, 32767, 1, 1));
    directed_rows.push_back(qrow(OP_SPHERE_X, 32767, -32768, 32767, 32767, 32767, 32767, 1, 1));
    directed_rows.push_back(qrow(OP_BOX_X, -32768, -32768, -32768, 32767, 32767, 32767, 1, 1));
    directed_rows.push_back(qrow(OP_BOX_IN, 32767, 32767, 32767, 32767, 32767, 32767, 1, 1));
    directed_rows.push_back(qrow(OP_BOX_IN, 0, 0, 0, 0, 0, 0, 1, 1));
    // Axis-aligned cube of half size 1000.
    directed_rows.push_back(crow(CFG_PLANE_NEAR, plane_word(0, 0, 16384, -1000)));
    directed_rows.push_back(crow(CFG_PLANE_RIGHT, plane_word(-16384, 0, 0, -1000)));
    directed_rows.push_back(crow(CFG_PLANE_LEFT, plane_word(16384, 0, 0, -1000)));
    directed_rows.push_back(crow(CFG_PLANE_BOTTOM, plane_word(0, 16384, 0, -1000)));
    directed_rows.push_back(crow(CFG_PLANE_TOP, plane_word(0, -16384, 0, -1000)));
    directed_rows.push_back(crow(CFG_PLANE_FAR, plane_word(0, 0, -16384, -1000)));
    directed_rows.push_back(qrow(OP_POINT_IN, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(qrow(OP_POINT_IN, 1000, -1000, 1000, 0, 0, 0, 0, 0));
    // Extents of a point query are ignored.
    directed_rows.push_back(qrow(OP_POINT_IN, 1001, 0, 0, 32767, 32767, 32767, 0, 0));
    // Only extent_x matters for a sphere.
    directed_rows.push_back(qrow(OP_SPHERE_X, 1500, 0, 0, 500, 32767, 32767, 0, 0));
    directed_rows.push_back(qrow(OP_SPHERE_X, 1500, 0, 0, 499, 0, 0, 0, 0));
    directed_rows.push_back(qrow(OP_BOX_X, 0, 1600, 0, 0, 600, 0, 0, 0));
    directed_rows.push_back(qrow(OP_BOX_X, 0, 1600, 0, 0, 599, 0, 0, 0));
    directed_rows.push_back(qrow(OP_BOX_IN, 0, 0, 0, 1000, 1000, 1000, 0, 0));
    directed_rows.push_back(qrow(OP_BOX_IN, 0, 0, 0, 1000, 1001, 1000, 0, 0));
    directed_rows.push_back(qrow(OP_POINT_IN, 0, 0, -1500, 0, 0, 0, 0, 0));
    directed_rows.push_back(qrow(OP_POINT_IN, 0, 0, 3000, 0, 0, 0, 0, 0));
    // With the far plane off only five planes are tested.
    directed_rows.push_back(crow(CFG_FAR_EN, 64'h0));
    directed_rows.push_back(qrow(OP_POINT_IN, 0, 0, 3000, 0, 0, 0, 0, 0));
    directed_rows.push_back(qrow(OP_BOX_IN, 0, 0, 20000, 10, 10, 12000, 0, 0));
    // A near normal of length two; the sphere radius is not scaled by it.
    directed_rows.push_back(crow(CFG_PLANE_NEAR, plane_word(0, 0, -32768, -32768)));
    directed_rows.push_back(qrow(OP_SPHERE_X, 0, 0, 20000, 7232, 0, 0, 0, 0));
    directed_rows.push_back(qrow(OP_SPHERE_X, 0, 0, 20000, 7231, 0, 0, 0, 0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG)
        write_reg(directed_rows[r].idx, directed_rows[r].word);
      else
        offer_query(directed_rows[r].q, directed_rows[r].typed, directed_rows[r].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      program_planes(ph, scale);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      // The sender keeps offering while results are held back, filling the chain.
      if (ph % 4 == 0)
        hold_req = 1'b1;
      for (int i = 0; i < 160; i++) begin
        if (i == 80)
          wait_idle();
        offer_query(rand_query(scale), 1'b0, 1'b0);
      end
    end

    in_tvalid = 1'b0;
    while (expected_passes.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (expected_passes.size() != 0) begin
      $error("%0d results never arrived", expected_passes.size());
      errors++;
    end

    $display("Checked %0d cull queries of all four kinds over %0d plane settings,",
             results_seen, settings_count + 1);
    $display("with the far plane on and off: %0d passed, %0d culled.",
             passing, results_seen - passing);
    if (errors == 0)
      $display("tb_frustum_plane_cull_test: clean");
    else
      $display("tb_frustum_plane_cull_test: errors");
    $finish;
  end

endmodule
